// File: rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque and its storage cells.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_REAR  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic                     push_front;  // shift toward rear, value into cell 0
    logic                     pop_front;   // shift toward front
    logic                     push_rear;   // value into the cell at wr_pos
    logic [IDX_W-1:0]         wr_pos;
    logic [IDX_W-1:0]         rear_pos;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// File: rtl/cdq_cell.sv
// ----------------------------------------------------------------------------
// cdq_cell
// One storage cell of the deque chain: shifts with its neighbors on front
// operations, loads on a rear push at its position, taps out when it is rear.
// ----------------------------------------------------------------------------
module cdq_cell
  import cdq_pkg::*;
(
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  input  logic [IDX_W-1:0]         idx,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic signed [DATA_W-1:0] right_data,
  output logic signed [DATA_W-1:0] data,
  output logic signed [DATA_W-1:0] rear_tap
);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.push_front) begin
      data_nxt = (idx == '0) ? cmd.value : left_data;
    end else if (cmd.pop_front) begin
      data_nxt = right_data;
    end else if (cmd.push_rear && (idx == cmd.wr_pos)) begin
      data_nxt = cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data     = data_r;
  assign rear_tap = (idx == cmd.rear_pos) ? data_r : '0;

endmodule

// File: rtl/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of DEPTH signed 32-bit entries held in a chain of cells.
// ----------------------------------------------------------------------------
//  channel  | ports                                    | handshake
//  ---------+------------------------------------------+---------------------
//  request  | in_req_type, in_push_value               | start && !busy
//  result   | out_pop_value, out_status, out_is_empty, | out_valid, 1 cycle
//           | out_is_full                              |
//
// One request per cycle while busy is low; its result is strobed on the following cycle.
// Front pushes and pops shift the whole cell chain by one; rear pushes write
// only the cell at the fill count and rear pops read the cell just below it.
// busy is set by reset and cleared once reset is released; the result side cannot stall.
// ----------------------------------------------------------------------------
module circular_deque
  import cdq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_req_type,
  input  logic signed [DATA_W-1:0] in_push_value,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_pop_value,
  output logic [1:0]               out_status,
  output logic                     out_is_empty,
  output logic                     out_is_full
);

  logic                     busy_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     valid_r, valid_nxt;
  logic signed [DATA_W-1:0] pop_value_r, pop_value_nxt;
  status_t                  status_r, status_nxt;
  logic                     empty_r, empty_nxt;
  logic                     full_r, full_nxt;

  logic                     accept;
  logic                     is_full, is_empty;
  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic signed [DATA_W-1:0] cell_tap  [DEPTH];
  logic signed [DATA_W-1:0] rear_data;

  assign accept   = start && !busy_r;
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);

  // Rear entry: exactly one cell taps out, the rest give zero
  always_comb begin
    rear_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_data = rear_data | cell_tap[i];
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.value      = in_push_value;
    cmd.wr_pos     = count_r[IDX_W-1:0];
    cmd.rear_pos   = IDX_W'(count_r - CNT_W'(1));
    count_nxt      = count_r;
    pop_value_nxt  = '0;
    status_nxt     = ST_DONE;
    valid_nxt      = accept;
    if (accept) begin
      unique case (req_t'(in_req_type))
        REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.push_front = (req_t'(in_req_type) == REQ_PUSH_FRONT);
            cmd.push_rear  = (req_t'(in_req_type) == REQ_PUSH_REAR);
            count_nxt      = count_r + CNT_W'(1);
          end
        end
        REQ_POP_FRONT, REQ_POP_REAR: begin
          if (is_empty) begin
            status_nxt    = ST_EMPTY;
            pop_value_nxt = -32'sd1;
          end else begin
            cmd.pop_front = (req_t'(in_req_type) == REQ_POP_FRONT);
            pop_value_nxt = cmd.pop_front ? cell_data[0] : rear_data;
            count_nxt     = count_r - CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
    empty_nxt = (count_nxt == '0);
    full_nxt  = (count_nxt == CNT_W'(DEPTH));
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_in, right_in;
    if (g == 0) begin : g_first
      assign left_in = in_push_value;
    end else begin : g_mid
      assign left_in = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_in = cell_data[g];
    end else begin : g_body
      assign right_in = cell_data[g+1];
    end
    cdq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (IDX_W'(g)),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[g]),
      .rear_tap   (cell_tap[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      count_r  <= '0;
      valid_r  <= 1'b0;
      status_r <= ST_DONE;
      empty_r  <= 1'b1;
      full_r   <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      count_r  <= count_nxt;
      valid_r  <= valid_nxt;
      status_r <= status_nxt;
      empty_r  <= empty_nxt;
      full_r   <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pop_value_r <= pop_value_nxt;
  end

  assign busy          = busy_r;
  assign out_valid     = valid_r;
  assign out_pop_value = pop_value_r;
  assign out_status    = status_r;
  assign out_is_empty  = empty_r;
  assign out_is_full   = full_r;

  // every accepted beat gives exactly one result beat on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted request produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result strobe without request");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> out_is_empty && (out_pop_value == -32'sd1))
    else $error("empty pop result inconsistent");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_empty && out_is_full))
    else $error("empty and full both set");

endmodule
